/* rtl/core/stu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_pkg
// Types and constants shared by the sighting table update unit.
// ----------------------------------------------------------------------------
package stu_pkg;

  localparam int ADDR_W  = 48;
  localparam int LEVEL_W = 8;
  localparam int TYPE_W  = 4;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 7;
  localparam int USED_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;

  // One stored table entry, as held in a single RAM word.
  typedef struct packed {
    logic [ADDR_W-1:0]         addr;
    logic [TYPE_W-1:0]         atype;
    logic [TIME_W-1:0]         first_time;
    logic [TIME_W-1:0]         last_time;
    logic [COUNT_W-1:0]        count;
    logic signed [LEVEL_W-1:0] peak;
  } entry_t;

endpackage

/* rtl/core/stu_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_ifs
// Valid/ready channels carrying sightings in and update results out.
// ----------------------------------------------------------------------------
interface stu_in_if;
  logic                                valid;
  logic                                ready;
  logic [stu_pkg::ADDR_W-1:0]          station_address;
  logic signed [stu_pkg::LEVEL_W-1:0]  signal_level;
  logic [stu_pkg::TYPE_W-1:0]          aircraft_type;
  logic [stu_pkg::TIME_W-1:0]          time_now;

  modport source (output valid, station_address, signal_level, aircraft_type, time_now,
                  input ready);
  modport sink (input valid, station_address, signal_level, aircraft_type, time_now,
                output ready);
endinterface

interface stu_out_if;
  logic                                valid;
  logic                                ready;
  logic                                was_hit;
  logic [stu_pkg::SLOT_W-1:0]          entry_slot;
  logic                                was_evicted;
  logic [stu_pkg::COUNT_W-1:0]         sight_count;
  logic signed [stu_pkg::LEVEL_W-1:0]  peak_level;
  logic [stu_pkg::TIME_W-1:0]          first_time;
  logic [stu_pkg::USED_W-1:0]          entries_used;

  modport source (output valid, was_hit, entry_slot, was_evicted, sight_count, peak_level,
                  first_time, entries_used, input ready);
  modport sink (input valid, was_hit, entry_slot, was_evicted, sight_count, peak_level,
                first_time, entries_used, output ready);
endinterface

/* rtl/core/stu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/sighting_table_update_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sighting_table_update_unit
// Associative table of station sightings with oldest-first replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in_sight carries one sighting per word (address, level, type, time).
//   out_result carries exactly one update result per sighting.
//   The unit takes a word only when idle. It then reads every occupied entry
//   through one RAM read port, one entry per cycle, comparing the address and
//   tracking the oldest first-seen time with a single comparator pair.
//   With entries occupied, the scan is followed by one read drain and one
//   write-back, which registers the result; the unit then returns to idle
//   before it takes the next word. With the table empty the scan is skipped
//   and the unit goes straight from idle to the write-back.
//   The result sits in an output register; the unit accepts and scans a new
//   sighting while it waits, but holds the write-back until the receiver has
//   taken the earlier word.
//   Reset empties the table at once by clearing the occupancy count; stale
//   RAM contents beyond that count are never read.
// ----------------------------------------------------------------------------
module sighting_table_update_unit #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  stu_in_if.sink      in_sight,
  stu_out_if.source   out_result
);

  localparam int IDXW = $clog2(TABLE_ENTRIES);
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int EW   = $bits(stu_pkg::entry_t);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_WRITE} state_t;

  state_t                                 state_r, state_nxt;
  logic [stu_pkg::ADDR_W-1:0]             key_addr_r, key_addr_nxt;
  logic signed [stu_pkg::LEVEL_W-1:0]     key_level_r, key_level_nxt;
  logic [stu_pkg::TYPE_W-1:0]             key_type_r, key_type_nxt;
  logic [stu_pkg::TIME_W-1:0]             key_now_r, key_now_nxt;
  logic [CW-1:0]                          n_r, n_nxt;
  logic [CW-1:0]                          cnt_r, cnt_nxt;
  logic [CW-1:0]                          used_r, used_nxt;
  logic                                   pend_r, pend_nxt;
  logic [IDXW-1:0]                        pend_idx_r, pend_idx_nxt;
  logic                                   hit_r, hit_nxt;
  logic [IDXW-1:0]                        hit_idx_r, hit_idx_nxt;
  stu_pkg::entry_t                        hit_ent_r, hit_ent_nxt;
  logic [stu_pkg::TIME_W-1:0]             min_first_r, min_first_nxt;
  logic [IDXW-1:0]                        min_idx_r, min_idx_nxt;

  logic                                   out_valid_r, out_valid_nxt;
  logic                                   out_hit_r, out_hit_nxt;
  logic [stu_pkg::SLOT_W-1:0]             out_slot_r, out_slot_nxt;
  logic                                   out_evict_r, out_evict_nxt;
  logic [stu_pkg::COUNT_W-1:0]            out_count_r, out_count_nxt;
  logic signed [stu_pkg::LEVEL_W-1:0]     out_peak_r, out_peak_nxt;
  logic [stu_pkg::TIME_W-1:0]             out_first_r, out_first_nxt;
  logic [stu_pkg::USED_W-1:0]             out_used_r, out_used_nxt;

  logic                                   ram_we;
  logic [IDXW-1:0]                        ram_waddr;
  stu_pkg::entry_t                        ram_wentry;
  logic                                   ram_re;
  logic [EW-1:0]                          ram_rbits;
  stu_pkg::entry_t                        rd_ent;

  logic                                   in_take;
  logic                                   out_free;
  logic                                   table_full;
  logic [CW-1:0]                          cnt_inc;

  stu_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (cnt_r[IDXW-1:0]),
    .rdata (ram_rbits)
  );

  assign rd_ent     = stu_pkg::entry_t'(ram_rbits);
  assign in_take    = in_sight.valid && (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_result.ready;
  assign table_full = (n_r == CW'(TABLE_ENTRIES));
  assign cnt_inc    = cnt_r + CW'(1);
  assign ram_re     = (state_r == S_SCAN);

  always_comb begin
    state_nxt     = state_r;
    key_addr_nxt  = key_addr_r;
    key_level_nxt = key_level_r;
    key_type_nxt  = key_type_r;
    key_now_nxt   = key_now_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    pend_nxt      = (state_r == S_SCAN);
    pend_idx_nxt  = cnt_r[IDXW-1:0];
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    min_first_nxt = min_first_r;
    min_idx_nxt   = min_idx_r;
    out_valid_nxt = out_valid_r && !out_result.ready;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    out_evict_nxt = out_evict_r;
    out_count_nxt = out_count_r;
    out_peak_nxt  = out_peak_r;
    out_first_nxt = out_first_r;
    out_used_nxt  = out_used_r;
    ram_we        = 1'b0;
    ram_waddr     = hit_idx_r;
    ram_wentry    = hit_ent_r;

    // Entry read in the previous cycle: first match wins, and the oldest
    // first-seen time is kept with the lowest index on ties.
    if (pend_r) begin
      if (!hit_r && (rd_ent.addr == key_addr_r)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = pend_idx_r;
        hit_ent_nxt = rd_ent;
      end
      if ((pend_idx_r == '0) || (rd_ent.first_time < min_first_r)) begin
        min_first_nxt = rd_ent.first_time;
        min_idx_nxt   = pend_idx_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          key_addr_nxt  = in_sight.station_address;
          key_level_nxt = in_sight.signal_level;
          key_type_nxt  = in_sight.aircraft_type;
          key_now_nxt   = in_sight.time_now;
          n_nxt         = used_r;
          cnt_nxt       = '0;
          hit_nxt       = 1'b0;
          state_nxt     = (used_r == '0) ? S_WRITE : S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == n_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          ram_we = 1'b1;
          if (hit_r) begin
            ram_waddr            = hit_idx_r;
            ram_wentry           = hit_ent_r;
            ram_wentry.last_time = key_now_r;
            if (hit_ent_r.count != stu_pkg::COUNT_MAX) begin
              ram_wentry.count = hit_ent_r.count + stu_pkg::COUNT_ONE;
            end
            if (key_level_r > hit_ent_r.peak) begin
              ram_wentry.peak = key_level_r;
            end
          end else begin
            ram_waddr             = table_full ? min_idx_r : n_r[IDXW-1:0];
            ram_wentry.addr       = key_addr_r;
            ram_wentry.atype      = key_type_r;
            ram_wentry.first_time = key_now_r;
            ram_wentry.last_time  = key_now_r;
            ram_wentry.count      = stu_pkg::COUNT_ONE;
            ram_wentry.peak       = key_level_r;
            if (!table_full) begin
              used_nxt = n_r + CW'(1);
            end
          end
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_slot_nxt  = stu_pkg::SLOT_W'(ram_waddr);
          out_evict_nxt = !hit_r && table_full;
          out_count_nxt = ram_wentry.count;
          out_peak_nxt  = ram_wentry.peak;
          out_first_nxt = ram_wentry.first_time;
          out_used_nxt  = stu_pkg::USED_W'(used_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_addr_r  <= key_addr_nxt;
    key_level_r <= key_level_nxt;
    key_type_r  <= key_type_nxt;
    key_now_r   <= key_now_nxt;
    n_r         <= n_nxt;
    cnt_r       <= cnt_nxt;
    pend_idx_r  <= pend_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_ent_r   <= hit_ent_nxt;
    min_first_r <= min_first_nxt;
    min_idx_r   <= min_idx_nxt;
    out_hit_r   <= out_hit_nxt;
    out_slot_r  <= out_slot_nxt;
    out_evict_r <= out_evict_nxt;
    out_count_r <= out_count_nxt;
    out_peak_r  <= out_peak_nxt;
    out_first_r <= out_first_nxt;
    out_used_r  <= out_used_nxt;
  end

  assign in_sight.ready          = (state_r == S_IDLE);
  assign out_result.valid        = out_valid_r;
  assign out_result.was_hit      = out_hit_r;
  assign out_result.entry_slot   = out_slot_r;
  assign out_result.was_evicted  = out_evict_r;
  assign out_result.sight_count  = out_count_r;
  assign out_result.peak_level   = out_peak_r;
  assign out_result.first_time   = out_first_r;
  assign out_result.entries_used = out_used_r;

endmodule

/* test/tb_sighting_table_update_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sighting_table_update_unit
// Self-checking bench for the sighting table update unit. Sightings are
// driven through the input channel in random bursts while the result channel
// stalls on its own pattern. A behavioural copy of the table predicts every
// result word, which is compared field by field as it is taken. The run
// primes the table with repeats of one station, walks a short table of
// directed sightings, then fills and churns the table with random traffic, so
// that oldest-first replacement and its tie-breaking get exercised.
// ----------------------------------------------------------------------------
module tb_sighting_table_update_unit;

  localparam int TABLE_ENTRIES = 128;
  localparam int N_DIRECTED    = 15;
  localparam int N_RANDOM      = 1000;
  // One first sighting of address zero plus a run of repeats of it.
  localparam int N_PRIME       = 35;

  typedef struct packed {
    logic [stu_pkg::ADDR_W-1:0]         addr;
    logic signed [stu_pkg::LEVEL_W-1:0] level;
    logic [stu_pkg::TYPE_W-1:0]         atype;
    logic [stu_pkg::TIME_W-1:0]         now;
  } sighting_t;

  typedef struct packed {
    logic                               hit;
    logic [stu_pkg::SLOT_W-1:0]         slot;
    logic                               evicted;
    logic [stu_pkg::COUNT_W-1:0]        count;
    logic signed [stu_pkg::LEVEL_W-1:0] peak;
    logic [stu_pkg::TIME_W-1:0]         first;
    logic [stu_pkg::USED_W-1:0]         used;
  } update_t;

  typedef struct {
    sighting_t sight;
    bit        typed;
    update_t   want;
  } probe_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  stu_in_if  in_sight_if ();
  stu_out_if out_result_if ();

  sighting_table_update_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sight  (in_sight_if),
    .out_result(out_result_if)
  );

  always #4 clk = ~clk;

  // Behavioural copy of the table.
  stu_pkg::entry_t stations [TABLE_ENTRIES];
  int          stations_used = 0;
  logic [stu_pkg::TIME_W-1:0] clock_now = '0;

  update_t     expected_updates [$];
  int unsigned mismatches = 0;
  bit          sender_idles = 1'b0;
  bit          receiver_stalls = 1'b0;
  int unsigned burst_left = 0;
  bit [31:0]   rx_phase = '0;

  function automatic update_t apply_sighting(sighting_t s);
    update_t u;
    int      slot;
    int      i;
    bit      found;
    u = '0;
    slot = 0;
    found = 1'b0;
    for (i = 0; i < stations_used; i++)
      if (!found && stations[i].addr == s.addr) begin
        found = 1'b1;
        slot = i;
      end
    if (found) begin
      stations[slot].last_time = s.now;
      if (stations[slot].count != stu_pkg::COUNT_MAX)
        stations[slot].count = stations[slot].count + stu_pkg::COUNT_ONE;
      if ($signed(s.level) > $signed(stations[slot].peak))
        stations[slot].peak = s.level;
    end else begin
      if (stations_used < TABLE_ENTRIES) begin
        slot = stations_used;
        stations_used++;
      end else begin
        // Full table: the oldest first sighting goes, lowest index on a tie.
        u.evicted = 1'b1;
        slot = 0;
        for (i = 1; i < TABLE_ENTRIES; i++)
          if (stations[i].first_time < stations[slot].first_time)
            slot = i;
      end
      stations[slot] = '{addr: s.addr, atype: s.atype, first_time: s.now,
                         last_time: s.now, count: stu_pkg::COUNT_ONE, peak: s.level};
    end
    u.hit   = found;
    u.slot  = slot[stu_pkg::SLOT_W-1:0];
    u.count = stations[slot].count;
    u.peak  = stations[slot].peak;
    u.first = stations[slot].first_time;
    u.used  = stations_used[stu_pkg::USED_W-1:0];
    return u;
  endfunction

  // Repeats of stored stations, near misses, all-zero or all-ones addresses and fresh
  // ones, with a clock that often stands still so that equal first-seen times are common.
  function automatic sighting_t random_sighting();
    sighting_t s;
    int        pick;
    int        tick;
    s.level = stu_pkg::LEVEL_W'($urandom);
    s.atype = stu_pkg::TYPE_W'($urandom);
    tick = $urandom_range(0, 99);
    if (tick < 60)
      clock_now = clock_now + $urandom_range(0, 2);
    else if (tick < 90)
      clock_now = clock_now + $urandom_range(3, 1000);
    else if (tick >= 97)
      clock_now = $urandom;
    s.now = (tick >= 90 && tick < 97) ? stu_pkg::TIME_W'($urandom) : clock_now;
    pick = $urandom_range(0, 99);
    if (pick < 45 && stations_used > 0)
      s.addr = stations[$urandom_range(0, stations_used - 1)].addr;
    else if (pick < 55 && stations_used > 0)
      s.addr = stations[$urandom_range(0, stations_used - 1)].addr ^
               (48'd1 << $urandom_range(0, stu_pkg::ADDR_W - 1));
    else if (pick < 60)
      s.addr = $urandom_range(0, 1) ? '1 : '0;
    else
      s.addr = stu_pkg::ADDR_W'({$urandom, $urandom});
    return s;
  endfunction

  task automatic send_sighting(input sighting_t s, input bit typed, input update_t want);
    update_t predicted;
    in_sight_if.valid           <= 1'b1;
    in_sight_if.station_address <= s.addr;
    in_sight_if.signal_level    <= s.level;
    in_sight_if.aircraft_type   <= s.atype;
    in_sight_if.time_now        <= s.now;
    do @(posedge clk); while (in_sight_if.ready !== 1'b1);
    predicted = apply_sighting(s);
    expected_updates.push_back(typed ? want : predicted);
    if (!sender_idles) begin
      burst_left = 0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_sight_if.valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // Holds the sender off until every outstanding result word has been taken.
  task automatic wait_for_results();
    in_sight_if.valid <= 1'b0;
    do @(posedge clk); while (expected_updates.size() != 0);
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // The receiver cycles through steady, random and periodic acceptance.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (!receiver_stalls) begin
      out_result_if.ready <= 1'b1;
    end else begin
      case (rx_phase[9:8])
        2'd0:    out_result_if.ready <= 1'b1;
        2'd1:    out_result_if.ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_result_if.ready <= (rx_phase[3:0] < 4'd5);
        default: out_result_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    update_t want;
    if (rst_n && out_result_if.valid === 1'b1 && out_result_if.ready === 1'b1) begin
      if (expected_updates.size() == 0) begin
        $error("result word taken with no sighting outstanding");
        mismatches++;
      end else begin
        want = expected_updates.pop_front();
        compare_field("was_hit", 64'(want.hit), 64'(out_result_if.was_hit));
        compare_field("entry_slot", 64'(want.slot), 64'(out_result_if.entry_slot));
        compare_field("was_evicted", 64'(want.evicted), 64'(out_result_if.was_evicted));
        compare_field("sight_count", 64'(want.count), 64'(out_result_if.sight_count));
        compare_field("peak_level", 64'(want.peak), 64'(out_result_if.peak_level));
        compare_field("first_time", 64'(want.first), 64'(out_result_if.first_time));
        compare_field("entries_used", 64'(want.used), 64'(out_result_if.entries_used));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb_sighting_table_update_unit failed");
    $finish;
  end

  initial begin
    probe_row_t directed_rows [N_DIRECTED];
    sighting_t  s;
    int         k;

    in_sight_if.valid           = 1'b0;
    in_sight_if.station_address = '0;
    in_sight_if.signal_level    = '0;
    in_sight_if.aircraft_type   = '0;
    in_sight_if.time_now        = '0;
    out_result_if.ready         = 1'b0;

    // Slot 0 holds address zero, first seen at time zero, seen many times.
    directed_rows = '{
      '{'{48'hFFFF_FFFF_FFFF, 8'sd127, 4'hF, 32'hFFFF_FFFF}, 1'b1,
        '{1'b0, 7'd1, 1'b0, 16'd1, 8'sd127, 32'hFFFF_FFFF, 8'd2}},
      // An equal level leaves the peak alone, as does a lower one.
      '{'{48'hFFFF_FFFF_FFFF, 8'sd127, 4'h0, 32'd5}, 1'b1,
        '{1'b1, 7'd1, 1'b0, 16'd2, 8'sd127, 32'hFFFF_FFFF, 8'd2}},
      '{'{48'hFFFF_FFFF_FFFF, 8'sh80, 4'h3, 32'd0}, 1'b1,
        '{1'b1, 7'd1, 1'b0, 16'd3, 8'sd127, 32'hFFFF_FFFF, 8'd2}},
      '{'{48'h0000_0000_0001, -8'sd1, 4'h7, 32'd100}, 1'b1,
        '{1'b0, 7'd2, 1'b0, 16'd1, -8'sd1, 32'd100, 8'd3}},
      '{'{48'h0000_0000_0001, 8'sd0, 4'h7, 32'd101}, 1'b1,
        '{1'b1, 7'd2, 1'b0, 16'd2, 8'sd0, 32'd100, 8'd3}},
      '{'{48'h0000_0000_0001, -8'sd5, 4'h2, 32'd102}, 1'b1,
        '{1'b1, 7'd2, 1'b0, 16'd3, 8'sd0, 32'd100, 8'd3}},
      '{'{48'h0000_0000_0000, 8'sd0, 4'h5, 32'd103}, 1'b0, '0},
      '{'{48'h8000_0000_0000, 8'sd1, 4'h8, 32'h8000_0000}, 1'b1,
        '{1'b0, 7'd3, 1'b0, 16'd1, 8'sd1, 32'h8000_0000, 8'd4}},
      '{'{48'h7FFF_FFFF_FFFF, 8'sh80, 4'h1, 32'h7FFF_FFFF}, 1'b1,
        '{1'b0, 7'd4, 1'b0, 16'd1, 8'sh80, 32'h7FFF_FFFF, 8'd5}},
      '{'{48'h7FFF_FFFF_FFFF, -8'sd127, 4'h1, 32'h7FFF_FFFF}, 1'b1,
        '{1'b1, 7'd4, 1'b0, 16'd2, -8'sd127, 32'h7FFF_FFFF, 8'd5}},
      // Same first-seen time as slot 0, so the two tie once the table fills.
      '{'{48'h0000_0000_0003, 8'sd64, 4'h9, 32'd0}, 1'b1,
        '{1'b0, 7'd5, 1'b0, 16'd1, 8'sd64, 32'd0, 8'd6}},
      '{'{48'hAAAA_AAAA_AAAA, 8'sh55, 4'hA, 32'hAAAA_AAAA}, 1'b1,
        '{1'b0, 7'd6, 1'b0, 16'd1, 8'sh55, 32'hAAAA_AAAA, 8'd7}},
      '{'{48'h5555_5555_5555, 8'shAA, 4'h5, 32'h5555_5555}, 1'b1,
        '{1'b0, 7'd7, 1'b0, 16'd1, 8'shAA, 32'h5555_5555, 8'd8}},
      '{'{48'h8000_0000_0000, 8'sd2, 4'h0, 32'd9}, 1'b1,
        '{1'b1, 7'd3, 1'b0, 16'd2, 8'sd2, 32'h8000_0000, 8'd8}},
      '{'{48'hFFFF_FFFF_FFFE, 8'sd0, 4'hE, 32'd1}, 1'b1,
        '{1'b0, 7'd8, 1'b0, 16'd1, 8'sd0, 32'd1, 8'd9}}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With a single entry each sighting is short, so these run back to back
    // and without stalls.
    for (k = 0; k < N_PRIME; k++) begin
      s.addr  = '0;
      s.level = (k == 0) ? 8'sh80 : stu_pkg::LEVEL_W'($urandom);
      s.atype = (k == 0) ? 4'h0 : stu_pkg::TYPE_W'($urandom);
      s.now   = k;
      send_sighting(s, 1'b0, '0);
    end
    wait_for_results();

    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    for (k = 0; k < N_DIRECTED; k++)
      send_sighting(directed_rows[k].sight, directed_rows[k].typed, directed_rows[k].want);
    wait_for_results();

    clock_now = 32'd200;
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 250 == 249)
        wait_for_results();
      send_sighting(random_sighting(), 1'b0, '0);
    end

    in_sight_if.valid <= 1'b0;
    do @(posedge clk); while (expected_updates.size() != 0);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (mismatches == 0)
      $display("tb_sighting_table_update_unit passed");
    else
      $display("tb_sighting_table_update_unit failed");
    $finish;
  end

endmodule
